### rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, codes and defaults for the stack bytecode machine.
// ----------------------------------------------------------------------------
package sbm_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF   = 256;
    localparam int REG_COUNT_DEF     = 16;
    localparam int PROGRAM_BYTES_DEF = 1024;

    // item functions
    localparam logic [1:0] FN_WRITE   = 2'd0;
    localparam logic [1:0] FN_RESTART = 2'd1;
    localparam logic [1:0] FN_EXEC    = 2'd2;

    // opcodes
    localparam logic [7:0] OP_NOP   = 8'd0;
    localparam logic [7:0] OP_PUSH  = 8'd1;
    localparam logic [7:0] OP_POP   = 8'd2;
    localparam logic [7:0] OP_LOAD  = 8'd3;
    localparam logic [7:0] OP_STORE = 8'd4;
    localparam logic [7:0] OP_JMP   = 8'd5;
    localparam logic [7:0] OP_JZ    = 8'd6;
    localparam logic [7:0] OP_JNZ   = 8'd7;
    localparam logic [7:0] OP_ADD   = 8'd8;
    localparam logic [7:0] OP_SUB   = 8'd9;
    localparam logic [7:0] OP_MUL   = 8'd10;
    localparam logic [7:0] OP_DIV   = 8'd11;
    localparam logic [7:0] OP_PRINT = 8'd12;
    localparam logic [7:0] OP_STOP  = 8'd13;

    // machine status codes
    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_STOP    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_BADREG  = 3'd4;
    localparam logic [2:0] ST_IPRANGE = 3'd5;
    localparam logic [2:0] ST_BADOP   = 3'd6;
    localparam logic [2:0] ST_DIVZERO = 3'd7;

    // stack address select
    typedef enum logic [1:0] {
        SS_SP,
        SS_TOP,
        SS_SECOND
    } stack_sel_t;

    // stack write data select
    typedef enum logic [1:0] {
        WD_IMM,
        WD_A,
        WD_R
    } wdata_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       clr_step;
        logic       prog_wr;
        logic       restart;
        logic       item_start;
        logic       prog_sel_opnd;
        logic       op_cap;
        logic       opnd_cap;
        logic       stack_wr;
        stack_sel_t stack_sel;
        wdata_sel_t wd_sel;
        logic       a_cap;
        logic       a_from_reg;
        logic       b_cap;
        logic       r_cap;
        logic       reg_wr;
        logic       sp_inc;
        logic       sp_dec;
        logic       ip_adv;
        logic [2:0] ip_len;
        logic       ip_jump;
        logic       st_set;
        logic [2:0] st_code;
        logic       pv_set;
        logic       div_start;
        logic       out_load;
    } sbm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       clr_done;
        logic       halted;
        logic       fetch_bad;
        logic       opnd_bad;
        logic       sp_zero;
        logic       sp_lt2;
        logic       sp_full;
        logic       reg_bad;
        logic       a_zero;
        logic       div_done;
        logic       out_busy;
        logic [7:0] opcode;
        logic [2:0] k;
    } sbm_stat_t;

endpackage

### rtl/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sbm_divider.sv
// ----------------------------------------------------------------------------
// sbm_divider
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sbm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic        done
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    // restoring step
    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[32] ? shifted : diff;
            quo_reg <= {quo_reg[30:0], ~diff[32]};
        end
    end

    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

### rtl/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath
// Machine state, memories, operand registers, alu and result register.
// ----------------------------------------------------------------------------
module sbm_datapath #(
    parameter int STACK_DEPTH   = sbm_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT     = sbm_pkg::REG_COUNT_DEF,
    parameter int PROGRAM_BYTES = sbm_pkg::PROGRAM_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbm_pkg::sbm_cmd_t cmd,
    output sbm_pkg::sbm_stat_t stat,
    input  logic [9:0]        load_address,
    input  logic [7:0]        load_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              print_valid,
    output logic [31:0]       print_value,
    output logic [2:0]        machine_status,
    output logic [15:0]       instruction_pointer
);

    localparam int AW   = $clog2(PROGRAM_BYTES);
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam int SPW  = SIW + 1;
    localparam int RIW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CLRN = (PROGRAM_BYTES > REG_COUNT) ? PROGRAM_BYTES : REG_COUNT;
    localparam int CW   = $clog2(CLRN);

    logic [15:0]    ip_reg;
    logic [SPW-1:0] sp_reg;
    logic [2:0]     status_reg;
    logic [CW-1:0]  clr_cnt_reg;
    logic [2:0]     k_reg;
    logic           pv_reg;
    logic           out_valid_reg;
    logic [7:0]     opcode_reg;
    logic [31:0]    imm_reg;
    logic [31:0]    a_reg;
    logic [31:0]    b_reg;
    logic [31:0]    r_reg;
    logic           out_pv_reg;
    logic [31:0]    out_val_reg;
    logic [2:0]     out_st_reg;
    logic [15:0]    out_ip_reg;

    logic [16:0]    opnd_addr;
    logic           load_in_range;
    logic [SPW-1:0] stack_addr_w;
    logic           prog_we;
    logic [AW-1:0]  prog_waddr;
    logic [7:0]     prog_wdata;
    logic [AW-1:0]  prog_raddr;
    logic [7:0]     prog_rdata;
    logic [31:0]    stack_wdata;
    logic [31:0]    stack_rdata;
    logic           reg_we;
    logic [RIW-1:0] reg_addr;
    logic [31:0]    reg_wdata;
    logic [31:0]    reg_rdata;
    logic [31:0]    quotient;
    logic           div_done;
    logic [31:0]    alu_out;
    logic           out_take;

    // address arithmetic
    assign opnd_addr     = 17'(ip_reg) + 17'd1 + 17'(k_reg);
    assign load_in_range = 17'(load_address) < 17'(PROGRAM_BYTES);

    always_comb
    begin
        case (cmd.stack_sel)
            sbm_pkg::SS_TOP:    stack_addr_w = sp_reg - SPW'(1);
            sbm_pkg::SS_SECOND: stack_addr_w = sp_reg - SPW'(2);
            default:            stack_addr_w = sp_reg;
        endcase
    end

    // program memory, cleared after reset and written by load beats
    assign prog_we    = (cmd.clr_step && (17'(clr_cnt_reg) < 17'(PROGRAM_BYTES)))
                        || (cmd.prog_wr && load_in_range);
    assign prog_waddr = cmd.clr_step ? clr_cnt_reg[AW-1:0] : AW'(load_address);
    assign prog_wdata = cmd.clr_step ? 8'd0 : load_byte;
    assign prog_raddr = cmd.prog_sel_opnd ? opnd_addr[AW-1:0] : ip_reg[AW-1:0];

    sbm_ram #(.WIDTH(8), .DEPTH(PROGRAM_BYTES)) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    // operand stack
    always_comb
    begin
        case (cmd.wd_sel)
            sbm_pkg::WD_A: stack_wdata = a_reg;
            sbm_pkg::WD_R: stack_wdata = r_reg;
            default:       stack_wdata = imm_reg;
        endcase
    end

    sbm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (cmd.stack_wr),
        .waddr (stack_addr_w[SIW-1:0]),
        .wdata (stack_wdata),
        .raddr (stack_addr_w[SIW-1:0]),
        .rdata (stack_rdata)
    );

    // register file, cleared after reset
    assign reg_we    = (cmd.clr_step && (17'(clr_cnt_reg) < 17'(REG_COUNT))) || cmd.reg_wr;
    assign reg_addr  = cmd.clr_step ? clr_cnt_reg[RIW-1:0] : imm_reg[RIW-1:0];
    assign reg_wdata = cmd.clr_step ? 32'd0 : a_reg;

    sbm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_addr),
        .wdata (reg_wdata),
        .raddr (reg_addr),
        .rdata (reg_rdata)
    );

    // divide unit
    sbm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // alu result select
    always_comb
    begin
        case (opcode_reg)
            sbm_pkg::OP_ADD: alu_out = b_reg + a_reg;
            sbm_pkg::OP_SUB: alu_out = b_reg - a_reg;
            sbm_pkg::OP_MUL: alu_out = b_reg * a_reg;
            default:         alu_out = quotient;
        endcase
    end

    assign out_take = out_valid_reg && !out_stall;

    // machine control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg        <= '0;
            sp_reg        <= '0;
            status_reg    <= sbm_pkg::ST_RUN;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (cmd.restart)
            begin
                ip_reg     <= '0;
                sp_reg     <= '0;
                status_reg <= sbm_pkg::ST_RUN;
            end
            if (cmd.ip_adv)
            begin
                ip_reg <= ip_reg + 16'(cmd.ip_len);
            end
            else if (cmd.ip_jump)
            begin
                ip_reg <= imm_reg[15:0];
            end
            if (cmd.sp_inc)
            begin
                sp_reg <= sp_reg + SPW'(1);
            end
            else if (cmd.sp_dec)
            begin
                sp_reg <= sp_reg - SPW'(1);
            end
            if (cmd.st_set)
            begin
                status_reg <= cmd.st_code;
            end
            if (cmd.op_cap)
            begin
                k_reg <= '0;
            end
            else if (cmd.opnd_cap)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (cmd.item_start)
            begin
                pv_reg <= 1'b0;
            end
            else if (cmd.pv_set)
            begin
                pv_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.op_cap)
        begin
            opcode_reg <= prog_rdata;
            imm_reg    <= '0;
        end
        else if (cmd.opnd_cap)
        begin
            imm_reg[8*k_reg[1:0] +: 8] <= prog_rdata;
        end
        if (cmd.a_cap)
        begin
            a_reg <= cmd.a_from_reg ? reg_rdata : stack_rdata;
        end
        if (cmd.b_cap)
        begin
            b_reg <= stack_rdata;
        end
        if (cmd.r_cap)
        begin
            r_reg <= alu_out;
        end
        if (cmd.out_load)
        begin
            out_pv_reg  <= pv_reg;
            out_val_reg <= pv_reg ? a_reg : 32'd0;
            out_st_reg  <= status_reg;
            out_ip_reg  <= ip_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.clr_done  = clr_cnt_reg == CW'(CLRN - 1);
        stat.halted    = status_reg != sbm_pkg::ST_RUN;
        stat.fetch_bad = 17'(ip_reg) >= 17'(PROGRAM_BYTES - 1);
        stat.opnd_bad  = opnd_addr >= 17'(PROGRAM_BYTES);
        stat.sp_zero   = sp_reg == '0;
        stat.sp_lt2    = sp_reg < SPW'(2);
        stat.sp_full   = sp_reg >= SPW'(STACK_DEPTH - 1);
        stat.reg_bad   = !({1'b0, imm_reg[7:0]} < 9'(REG_COUNT));
        stat.a_zero    = a_reg == 32'd0;
        stat.div_done  = div_done;
        stat.out_busy  = out_valid_reg && out_stall;
        stat.opcode    = opcode_reg;
        stat.k         = k_reg;
    end

    assign out_valid           = out_valid_reg;
    assign print_valid         = out_pv_reg;
    assign print_value         = out_val_reg;
    assign machine_status      = out_st_reg;
    assign instruction_pointer = out_ip_reg;

endmodule

### rtl/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: clearing pass, item dispatch and instruction steps.
// ----------------------------------------------------------------------------
module sbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  sbm_pkg::sbm_stat_t stat,
    output sbm_pkg::sbm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_OPC,
        S_OPND,
        S_OPNDW,
        S_EXEC,
        S_RDW,
        S_ACT,
        S_RD2W,
        S_ALU,
        S_DIVW,
        S_WB,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] n_opnd;

    // operand byte count per opcode
    always_comb
    begin
        case (stat.opcode) inside
            sbm_pkg::OP_PUSH:                              n_opnd = 3'd4;
            sbm_pkg::OP_LOAD, sbm_pkg::OP_STORE:           n_opnd = 3'd1;
            sbm_pkg::OP_JMP, sbm_pkg::OP_JZ, sbm_pkg::OP_JNZ: n_opnd = 3'd2;
            default:                                       n_opnd = 3'd0;
        endcase
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_start = 1'b1;
                    state_next     = S_DONE;
                    unique case (func)
                        sbm_pkg::FN_WRITE:   cmd.prog_wr = 1'b1;
                        sbm_pkg::FN_RESTART: cmd.restart = 1'b1;
                        sbm_pkg::FN_EXEC:
                        begin
                            if (!stat.halted)
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                if (stat.fetch_bad)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = sbm_pkg::ST_IPRANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_OPC;
                end
            end
            S_OPC:
            begin
                cmd.op_cap = 1'b1;
                state_next = S_OPND;
            end
            S_OPND:
            begin
                cmd.prog_sel_opnd = 1'b1;
                if (stat.k == n_opnd)
                begin
                    state_next = S_EXEC;
                end
                else if (stat.opnd_bad)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = sbm_pkg::ST_IPRANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_OPNDW;
                end
            end
            S_OPNDW:
            begin
                cmd.opnd_cap = 1'b1;
                state_next   = S_OPND;
            end
            S_EXEC:
            begin
                cmd.stack_sel = sbm_pkg::SS_TOP;
                state_next    = S_DONE;
                cmd.st_set    = 1'b1;
                cmd.st_code   = sbm_pkg::ST_RUN;
                unique case (stat.opcode) inside
                    sbm_pkg::OP_NOP:
                    begin
                        cmd.ip_adv = 1'b1;
                        cmd.ip_len = 3'd1;
                    end
                    sbm_pkg::OP_PUSH:
                    begin
                        if (stat.sp_full)
                        begin
                            cmd.st_code = sbm_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.stack_sel = sbm_pkg::SS_SP;
                            cmd.wd_sel    = sbm_pkg::WD_IMM;
                            cmd.stack_wr  = 1'b1;
                            cmd.sp_inc    = 1'b1;
                            cmd.ip_adv    = 1'b1;
                            cmd.ip_len    = 3'd5;
                        end
                    end
                    sbm_pkg::OP_POP:
                    begin
                        if (stat.sp_zero)
                        begin
                            cmd.st_code = sbm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.sp_dec = 1'b1;
                            cmd.ip_adv = 1'b1;
                            cmd.ip_len = 3'd1;
                        end
                    end
                    sbm_pkg::OP_LOAD:
                    begin
                        if (stat.reg_bad)
                        begin
                            cmd.st_code = sbm_pkg::ST_BADREG;
                        end
                        else if (stat.sp_full)
                        begin
                            cmd.st_code = sbm_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = S_RDW;
                        end
                    end
                    sbm_pkg::OP_STORE:
                    begin
                        if (stat.reg_bad)
                        begin
                            cmd.st_code = sbm_pkg::ST_BADREG;
                        end
                        else if (stat.sp_zero)
                        begin
                            cmd.st_code = sbm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_RDW;
                        end
                    end
                    sbm_pkg::OP_JMP:
                    begin
                        cmd.ip_jump = 1'b1;
                    end
                    sbm_pkg::OP_JZ, sbm_pkg::OP_JNZ, sbm_pkg::OP_PRINT:
                    begin
                        if (stat.sp_zero)
                        begin
                            cmd.st_code = sbm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_RDW;
                        end
                    end
                    sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL, sbm_pkg::OP_DIV:
                    begin
                        if (stat.sp_lt2)
                        begin
                            cmd.st_code = sbm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_RDW;
                        end
                    end
                    sbm_pkg::OP_STOP:
                    begin
                        cmd.st_code = sbm_pkg::ST_STOP;
                    end
                    default:
                    begin
                        cmd.st_code = sbm_pkg::ST_BADOP;
                    end
                endcase
            end
            S_RDW:
            begin
                cmd.a_cap      = 1'b1;
                cmd.a_from_reg = stat.opcode == sbm_pkg::OP_LOAD;
                state_next     = S_ACT;
            end
            S_ACT:
            begin
                state_next = S_DONE;
                unique case (stat.opcode) inside
                    sbm_pkg::OP_LOAD:
                    begin
                        cmd.stack_sel = sbm_pkg::SS_SP;
                        cmd.wd_sel    = sbm_pkg::WD_A;
                        cmd.stack_wr  = 1'b1;
                        cmd.sp_inc    = 1'b1;
                        cmd.ip_adv    = 1'b1;
                        cmd.ip_len    = 3'd2;
                    end
                    sbm_pkg::OP_STORE:
                    begin
                        cmd.reg_wr = 1'b1;
                        cmd.sp_dec = 1'b1;
                        cmd.ip_adv = 1'b1;
                        cmd.ip_len = 3'd2;
                    end
                    sbm_pkg::OP_JZ, sbm_pkg::OP_JNZ:
                    begin
                        cmd.sp_dec = 1'b1;
                        if ((stat.opcode == sbm_pkg::OP_JZ) == stat.a_zero)
                        begin
                            cmd.ip_jump = 1'b1;
                        end
                        else
                        begin
                            cmd.ip_adv = 1'b1;
                            cmd.ip_len = 3'd3;
                        end
                    end
                    sbm_pkg::OP_PRINT:
                    begin
                        cmd.pv_set = 1'b1;
                        cmd.sp_dec = 1'b1;
                        cmd.ip_adv = 1'b1;
                        cmd.ip_len = 3'd1;
                    end
                    sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL, sbm_pkg::OP_DIV:
                    begin
                        cmd.stack_sel = sbm_pkg::SS_SECOND;
                        state_next    = S_RD2W;
                    end
                    default: ;
                endcase
            end
            S_RD2W:
            begin
                cmd.b_cap  = 1'b1;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (stat.opcode != sbm_pkg::OP_DIV)
                begin
                    cmd.r_cap  = 1'b1;
                    state_next = S_WB;
                end
                else if (stat.a_zero)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = sbm_pkg::ST_DIVZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.r_cap  = 1'b1;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.stack_sel = sbm_pkg::SS_SECOND;
                cmd.wd_sel    = sbm_pkg::WD_R;
                cmd.stack_wr  = 1'b1;
                cmd.sp_dec    = 1'b1;
                cmd.ip_adv    = 1'b1;
                cmd.ip_len    = 3'd1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

### rtl/stack_bytecode_machine.sv
// ----------------------------------------------------------------------------
// stack_bytecode_machine
// Bytecode stack machine with program memory, operand stack and registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | func, load_address, load_byte
//  out     | output    | out_valid / out_stall | print_valid, print_value,
//          |           |                       | machine_status, instruction_pointer
//
// a write, restart or halted step beat goes straight to the result; a step's
// length is set by byte-wide program memory fetches (one per operand byte)
// and one-port stack reads; div also waits on the iterative divider.
// after reset a clearing pass zeroes program memory and registers while
// in_stall is high.
// a new beat is taken while the previous result waits under out_stall.
module stack_bytecode_machine #(
    parameter int STACK_DEPTH   = sbm_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT     = sbm_pkg::REG_COUNT_DEF,
    parameter int PROGRAM_BYTES = sbm_pkg::PROGRAM_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [9:0]         load_address,
    input  logic [7:0]         load_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               print_valid,
    output logic signed [31:0] print_value,
    output logic [2:0]         machine_status,
    output logic [15:0]        instruction_pointer
);

    sbm_pkg::sbm_cmd_t  cmd;
    sbm_pkg::sbm_stat_t stat;
    logic [31:0]        pval;

    // sequencer
    sbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    sbm_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .REG_COUNT     (REG_COUNT),
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .load_address        (load_address),
        .load_byte           (load_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .print_valid         (print_valid),
        .print_value         (pval),
        .machine_status      (machine_status),
        .instruction_pointer (instruction_pointer)
    );

    assign print_value = signed'(pval);

    // one beat in flight at a time
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // a print only completes on a running machine
    a_print_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && print_valid) |-> (machine_status == sbm_pkg::ST_RUN))
        else $error("print reported with halted status");

    // no print value without a print
    a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !print_valid) |-> (print_value == 32'sd0))
        else $error("print value nonzero without print");

endmodule
